[design/tec_pkg.sv]
// Package for the extended timer compare scheduler.
// Holds the word types, operation codes, reset constants and masks; no dependencies.
package tec_pkg;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_SERVICE  = 2'd2;

    localparam logic [63:0] IDLE_TICKS = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [31:0] HALF_FLAG  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] counter_first;
        logic [31:0] counter_second;
        logic [63:0] target_ticks;
    } t_item;

    typedef struct packed {
        logic [63:0] ticks;
        logic        force_interrupt;
        logic        match_written;
        logic [31:0] match_value;
        logic        callback_due;
    } t_result;

endpackage

[design/tec_core.sv]
// Timer state and the single-pass compute for one word.
// Depends on tec_pkg for the word types, operation codes and constants.
module tec_core import tec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_result
);

    logic [63:0] r_last_reading, n_last_reading;
    logic [63:0] r_next_target, n_next_target;
    logic [31:0] r_match_register, n_match_register;

    always_comb begin
        logic [31:0] hi, hc, lc, hr, lr, nc, d1, d2, c1, c2;
        logic [63:0] tk, lr64, tg;
        logic        f, wr, due, sched;

        c1 = i_item.counter_first;
        c2 = i_item.counter_second;
        hi = r_last_reading[63:32];
        if (((r_last_reading[31:0] ^ c1) & HALF_FLAG) != 32'd0 && c1[31] == 1'b0) begin
            hi = hi + 32'd1;
        end
        tk = {hi, c1};

        lr64  = r_last_reading;
        tg    = r_next_target;
        f     = 1'b0;
        wr    = 1'b0;
        due   = 1'b0;
        sched = 1'b0;
        nc    = r_match_register;
        n_match_register = r_match_register;

        unique case (i_item.operation)
            OP_SCHEDULE: begin
                sched = 1'b1;
                tg    = i_item.target_ticks;
            end
            OP_SERVICE: begin
                lr64 = tk;
                if (tk >= r_next_target) begin
                    due = 1'b1;
                end else begin
                    sched = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (sched) begin
            if (tg >= IDLE_TICKS && lr64 >= IDLE_TICKS) begin
                tg   = (tg > lr64) ? tg - lr64 : 64'd0;
                lr64 = 64'd0;
            end
        end

        hc = tg[63:32];
        lc = tg[31:0];
        hr = lr64[63:32];
        lr = lr64[31:0];
        d1 = 32'd0;
        d2 = 32'd0;

        if (sched) begin
            if (((lr ^ c1) & HALF_FLAG) != 32'd0) begin
                f = 1'b1;
            end else begin
                lr = c1;
                if (hc < hr) begin
                    f = 1'b1;
                end else if (hc == hr) begin
                    if (lc <= lr) begin
                        f = 1'b1;
                    end
                end else begin
                    lc = ALL_ONES;
                end
                if (!f) begin
                    nc = lr[31] ? 32'd0 : HALF_FLAG;
                    d1 = lc - lr;
                    d2 = nc - lr;
                    if (d1 != 32'd0 && d1[31] == 1'b0 && $signed(d1) < $signed(d2)) begin
                        nc = lc;
                    end
                    n_match_register = nc;
                    wr = 1'b1;
                    if (((nc - c2) & HALF_FLAG) != 32'd0) begin
                        f = 1'b1;
                    end
                end
            end
        end

        n_last_reading = lr64;
        n_next_target  = tg;

        o_result.ticks           = tk;
        o_result.force_interrupt = f;
        o_result.match_written   = wr;
        o_result.match_value     = n_match_register;
        o_result.callback_due    = due;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_reading   <= 64'd0;
            r_next_target    <= IDLE_TICKS;
            r_match_register <= HALF_FLAG;
        end else if (i_en) begin
            r_last_reading   <= n_last_reading;
            r_next_target    <= n_next_target;
            r_match_register <= n_match_register;
        end
    end

endmodule

[design/timer_extend_and_compare_schedule.sv]
// One word a cycle while the downstream does not stall: a word is held in the input
// register, passes through the compute of tec_core while the 64-bit timer state
// updates, and lands in the result register, from which it is shown; a new word is
// taken every cycle while results are drained, and the throughput is bounded only by
// the downstream stall. Results appear in order, one per accepted word.
// Depends on tec_pkg and tec_core.
module timer_extend_and_compare_schedule import tec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_counter_first,
    input  logic [31:0] i_counter_second,
    input  logic [63:0] i_target_ticks,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_ticks,
    output logic        o_force_interrupt,
    output logic        o_match_written,
    output logic [31:0] o_match_value,
    output logic        o_callback_due
);

    logic    r_in_valid, r_out_valid;
    t_item   r_in;
    t_result r_out, core_result;
    logic    out_load, in_load;

    assign out_load = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !out_load;
    assign in_load  = i_valid && !o_stall;

    tec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (out_load),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_load || (r_in_valid && !out_load);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.operation      <= i_operation;
            r_in.counter_first  <= i_counter_first;
            r_in.counter_second <= i_counter_second;
            r_in.target_ticks   <= i_target_ticks;
        end
        if (out_load) begin
            r_out <= core_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_ticks           = r_out.ticks;
    assign o_force_interrupt = r_out.force_interrupt;
    assign o_match_written   = r_out.match_written;
    assign o_match_value     = r_out.match_value;
    assign o_callback_due    = r_out.callback_due;

endmodule

[design/tec_checker.sv]
// Port-level checks for the extended timer compare scheduler.
// Bound to timer_extend_and_compare_schedule; uses no package.
module tec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_ticks,
    input logic        o_force_interrupt,
    input logic        o_match_written,
    input logic [31:0] o_match_value,
    input logic        o_callback_due
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result word dropped while stalled.");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_ticks) && $stable(o_match_value))
        else $error("Stalled result word changed.");

    a_due_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_callback_due |-> !o_match_written && !o_force_interrupt)
        else $error("Due callback came with a match write or a forced interrupt.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("Result shown right after reset.");

endmodule

bind timer_extend_and_compare_schedule tec_checker u_tec_checker (.*);
